>>> rtl/tctr_pkg.sv
`timescale 1ns / 1ps
package tctr_pkg;

    localparam int unsigned CMD_W    = 3;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FILL_W   = 2;
    localparam int unsigned XY_W     = 16;
    localparam int unsigned SLOT_W   = 6;
    localparam int unsigned COUNT_W  = 7;
    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Table geometry, tied to the slot and count field widths above.
    localparam int unsigned NUM_SLOTS  = 64;
    localparam int unsigned COORD_BITS = XY_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ACQUIRE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FILL     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MINIMISE = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOROOM   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd5;

    // Fill states.
    localparam logic [FILL_W-1:0] FILL_DATA = 2'd0;
    localparam logic [FILL_W-1:0] FILL_CALC = 2'd1;
    localparam logic [FILL_W-1:0] FILL_PEND = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [XY_W-1:0]  tile_x;
        logic [XY_W-1:0]  tile_y;
    } tctr_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [FILL_W-1:0]   tile_state;
        logic [XY_W-1:0]     evicted_x;
        logic [XY_W-1:0]     evicted_y;
        logic [COUNT_W-1:0]  entries_in_use;
    } tctr_out_t;

    // Datapath operations issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_SCAN  = 3'd1,
        OP_READ  = 3'd2,
        OP_WRITE = 3'd3,
        OP_START = 3'd4
    } tctr_op_t;

    typedef struct packed {
        tctr_op_t op;
    } tctr_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic rd_valid;
    } tctr_stat_t;

endpackage

>>> rtl/tctr_ctrl.sv
`timescale 1ns / 1ps
module tctr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output tctr_pkg::tctr_cmd_t cmd,
    input  tctr_pkg::tctr_stat_t stat
);
    import tctr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_READ  = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Sequence: scan all slots, read the chosen entry, write back, present.
    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_START;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.op = OP_SCAN;
                if (stat.scan_done) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.op = OP_READ;
                if (stat.rd_valid) begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.op     = OP_WRITE;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/tctr_datapath.sv
`timescale 1ns / 1ps
module tctr_datapath #(
    parameter int unsigned REF_BITS   = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [tctr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tctr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  tctr_pkg::tctr_in_t    in_item,
    input  tctr_pkg::tctr_cmd_t   cmd,
    output tctr_pkg::tctr_stat_t  stat,
    output tctr_pkg::tctr_out_t   out_item
);
    import tctr_pkg::*;

    localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CW = $clog2(NUM_SLOTS + 1);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    // Per-slot control bits in flip-flops; payload in a memory.
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] unref_reg;
    logic [COORD_BITS-1:0] left_mem  [NUM_SLOTS];
    logic [COORD_BITS-1:0] top_mem   [NUM_SLOTS];
    logic [FILL_W-1:0]     fill_mem  [NUM_SLOTS];
    logic [REF_BITS-1:0]   refs_mem  [NUM_SLOTS];
    logic [STAMP_W-1:0]    stamp_mem [NUM_SLOTS];

    logic [COUNT_W-1:0]  max_entries_reg;
    logic                policy_reg;
    logic [XY_W-1:0]     image_height_reg;
    logic [STAMP_W-1:0]  use_clock_reg;
    logic [CW-1:0]       live_reg;

    logic [CMD_W-1:0]      cmd_reg;
    logic [COORD_BITS-1:0] x_reg, y_reg;
    logic [CW-1:0]         idx_reg;
    logic                  hit_found_reg, free_found_reg, vic_found_reg;
    logic [IW-1:0]         hit_reg, free_reg, vic_reg;
    logic [STAMP_W-1:0]    bound_reg;
    logic                  rd_valid_reg;
    logic [COORD_BITS-1:0] rd_left_reg, rd_top_reg;
    logic [FILL_W-1:0]     rd_fill_reg;
    logic [REF_BITS-1:0]   rd_refs_reg;
    logic [STAMP_W-1:0]    rd_stamp_reg;
    logic [COORD_BITS-1:0] sc_left_reg, sc_top_reg;
    logic [STAMP_W-1:0]    sc_stamp_reg;
    logic                  sc_valid_reg;
    logic [IW-1:0]         sc_idx_reg;
    tctr_out_t             out_reg;

    logic [IW-1:0] scan_idx;
    logic [IW-1:0] tgt;
    logic          use_repl;
    logic [STAMP_W-1:0] sc_key;
    logic [STAMP_W-1:0] stamp_now;

    assign scan_idx  = idx_reg[IW-1:0];
    assign use_repl  = ({{(32-COUNT_W){1'b0}}, max_entries_reg} <= 32'(live_reg));
    assign sc_key    = policy_reg ? STAMP_W'(sc_top_reg) : sc_stamp_reg;
    assign stamp_now = use_clock_reg;

    // Target slot for the read and write-back.
    always_comb begin
        tgt = hit_reg;
        if (cmd_reg == CMD_ACQUIRE && !hit_found_reg) begin
            tgt = (use_repl && vic_found_reg) ? vic_reg : free_reg;
        end
    end

    assign stat.scan_done = (idx_reg == CW'(NUM_SLOTS)) && !sc_valid_reg;
    assign stat.rd_valid  = rd_valid_reg;
    assign out_item       = out_reg;

    // Memory read: one port for the scan, one registered read of the target.
    always_ff @(posedge aclk) begin
        sc_left_reg  <= left_mem[scan_idx];
        sc_top_reg   <= top_mem[scan_idx];
        sc_stamp_reg <= stamp_mem[scan_idx];
        rd_left_reg  <= left_mem[tgt];
        rd_top_reg   <= top_mem[tgt];
        rd_fill_reg  <= fill_mem[tgt];
        rd_refs_reg  <= refs_mem[tgt];
        rd_stamp_reg <= stamp_mem[tgt];
    end

    // Memory write-back of the target entry.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_WRITE && cmd_reg <= CMD_FILL) begin
            if (cmd_reg == CMD_ACQUIRE && hit_found_reg) begin
                stamp_mem[tgt] <= stamp_now;
                refs_mem[tgt]  <= (rd_refs_reg != REF_MAX) ? rd_refs_reg + 1'b1 : rd_refs_reg;
            end else if (cmd_reg == CMD_ACQUIRE) begin
                if ((use_repl && vic_found_reg) || free_found_reg) begin
                    left_mem[tgt] <= x_reg;
                    top_mem[tgt]  <= y_reg;
                    fill_mem[tgt] <= FILL_PEND;
                    refs_mem[tgt] <= REF_BITS'(1);
                    if (!(use_repl && vic_found_reg)) begin
                        stamp_mem[tgt] <= stamp_now;
                    end
                end
            end else if (hit_found_reg) begin
                if (cmd_reg == CMD_RELEASE) begin
                    refs_mem[tgt] <= (rd_refs_reg != '0) ? rd_refs_reg - 1'b1 : rd_refs_reg;
                end else if (cmd_reg == CMD_START) begin
                    if (rd_fill_reg == FILL_PEND) begin
                        fill_mem[tgt] <= FILL_CALC;
                    end
                end else begin
                    fill_mem[tgt]  <= FILL_DATA;
                    stamp_mem[tgt] <= stamp_now;
                end
            end
        end
    end

    // Control state, scan bookkeeping and the result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            unref_reg        <= '0;
            max_entries_reg  <= COUNT_W'(64);
            policy_reg       <= 1'b0;
            image_height_reg <= 16'hFFFF;
            use_clock_reg    <= '0;
            live_reg         <= '0;
            rd_valid_reg     <= 1'b0;
            sc_valid_reg     <= 1'b0;
            idx_reg          <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_MAX_ENTRIES:  max_entries_reg  <= cfg_data[COUNT_W-1:0];
                    CFG_POLICY:       policy_reg       <= cfg_data[0];
                    CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[XY_W-1:0];
                    default: ;
                endcase
            end
            rd_valid_reg <= (cmd.op == OP_READ);
            case (cmd.op)
                OP_START: begin
                    cmd_reg        <= in_item.command;
                    x_reg          <= in_item.tile_x[COORD_BITS-1:0];
                    y_reg          <= in_item.tile_y[COORD_BITS-1:0];
                    idx_reg        <= '0;
                    sc_valid_reg   <= 1'b0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    vic_found_reg  <= 1'b0;
                    hit_reg        <= '0;
                    free_reg       <= '0;
                    vic_reg        <= '0;
                    bound_reg      <= policy_reg ? STAMP_W'(image_height_reg) : use_clock_reg;
                end
                OP_SCAN: begin
                    // Issue a read per cycle; compare the registered result in the next cycle.
                    if (idx_reg != CW'(NUM_SLOTS)) begin
                        sc_idx_reg   <= scan_idx;
                        sc_valid_reg <= 1'b1;
                        idx_reg      <= idx_reg + 1'b1;
                    end else begin
                        sc_valid_reg <= 1'b0;
                    end
                    if (sc_valid_reg) begin
                        if (valid_reg[sc_idx_reg]) begin
                            if (!hit_found_reg && sc_left_reg == x_reg && sc_top_reg == y_reg) begin
                                hit_found_reg <= 1'b1;
                                hit_reg       <= sc_idx_reg;
                            end
                            if (unref_reg[sc_idx_reg] && sc_key < bound_reg) begin
                                bound_reg     <= sc_key;
                                vic_found_reg <= 1'b1;
                                vic_reg       <= sc_idx_reg;
                            end
                        end else if (!free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_reg       <= sc_idx_reg;
                        end
                    end
                end
                OP_WRITE: begin
                    out_reg.evicted_x  <= '0;
                    out_reg.evicted_y  <= '0;
                    out_reg.slot       <= '0;
                    out_reg.tile_state <= FILL_DATA;
                    out_reg.status     <= ST_NOTFOUND;
                    out_reg.entries_in_use <= COUNT_W'(live_reg);
                    case (cmd_reg)
                        CMD_ACQUIRE: begin
                            out_reg.slot       <= SLOT_W'(tgt);
                            out_reg.tile_state <= FILL_PEND;
                            if (hit_found_reg) begin
                                out_reg.status     <= ST_HIT;
                                out_reg.tile_state <= rd_fill_reg;
                                unref_reg[tgt]     <= 1'b0;
                                if (use_clock_reg != '1) use_clock_reg <= use_clock_reg + 1'b1;
                            end else if (use_repl && vic_found_reg) begin
                                out_reg.status    <= ST_REUSED;
                                out_reg.evicted_x <= XY_W'(rd_left_reg);
                                out_reg.evicted_y <= XY_W'(rd_top_reg);
                                unref_reg[tgt]    <= 1'b0;
                            end else if (free_found_reg) begin
                                out_reg.status         <= ST_NEW;
                                valid_reg[tgt]         <= 1'b1;
                                unref_reg[tgt]         <= 1'b0;
                                live_reg               <= live_reg + 1'b1;
                                out_reg.entries_in_use <= COUNT_W'(live_reg + 1'b1);
                            end else begin
                                out_reg.status     <= ST_NOROOM;
                                out_reg.slot       <= '0;
                                out_reg.tile_state <= FILL_DATA;
                            end
                        end
                        CMD_RELEASE, CMD_START, CMD_FILL: begin
                            if (hit_found_reg) begin
                                out_reg.status     <= ST_DONE;
                                out_reg.slot       <= SLOT_W'(tgt);
                                out_reg.tile_state <= rd_fill_reg;
                                if (cmd_reg == CMD_RELEASE) begin
                                    unref_reg[tgt] <= (rd_refs_reg <= REF_BITS'(1));
                                end else if (cmd_reg == CMD_START) begin
                                    if (rd_fill_reg == FILL_PEND)
                                        out_reg.tile_state <= FILL_CALC;
                                end else begin
                                    out_reg.tile_state <= FILL_DATA;
                                    if (use_clock_reg != '1)
                                        use_clock_reg <= use_clock_reg + 1'b1;
                                end
                            end
                        end
                        CMD_MINIMISE: begin
                            valid_reg <= valid_reg & ~unref_reg;
                            live_reg  <= CW'($countones(valid_reg & ~unref_reg));
                            out_reg.entries_in_use <=
                                COUNT_W'($countones(valid_reg & ~unref_reg));
                            out_reg.status <= ST_DONE;
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/tile_cache_tag_replacement.sv
`timescale 1ns / 1ps
// Channel   | Direction | Ports
// input     | in        | s_valid, s_ready, s_item (command, tile_x, tile_y)
// result    | out       | m_valid, m_ready, m_item (status .. entries_in_use)
// config    | in        | cfg_we, cfg_index, cfg_data
// Each item runs a scan of the tag memory, one slot a cycle, then a registered read of
// the target entry and a write-back, before its result is presented.
// One item is in flight at a time; s_ready is high only while idle.
// The result is held in an output register until m_ready takes it.
// Reset (aresetn low, synchronous) clears valid bits, counters and control state.
module tile_cache_tag_replacement #(
    parameter int unsigned REF_BITS   = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tctr_pkg::tctr_in_t    s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tctr_pkg::tctr_out_t   m_item,
    input  logic                  cfg_we,
    input  logic [tctr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tctr_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tctr_pkg::*;

    tctr_cmd_t  cmd;
    tctr_stat_t stat;

    tctr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tctr_datapath #(
        .REF_BITS   (REF_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (s_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (m_item)
    );

endmodule

>>> rtl/tctr_checker.sv
`timescale 1ns / 1ps
module tctr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input tctr_pkg::tctr_out_t m_item
);
    import tctr_pkg::*;

    // One item at a time: no input is taken while a result is shown.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input ready while result valid");

    // A result is held until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result dropped or changed");

    // Status codes stay in range.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.status <= ST_DONE) else $error("bad status");

    // Eviction coordinates only accompany a reused entry.
    a_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.status != ST_REUSED |->
            m_item.evicted_x == '0 && m_item.evicted_y == '0)
        else $error("stray eviction coordinates");

endmodule

bind tile_cache_tag_replacement tctr_checker u_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
